### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

### rtl/vgc_pkg.sv
// Types, constants and the letter code function of the 27-letter Vigenere cipher.
`default_nettype none

package vgc_pkg;

    localparam int KEY_LETTERS_MAX  = 24;
    localparam int ALPHABET_SIZE    = 27;
    localparam int LETTERS_PER_WORD = 12;
    localparam int CODE_W           = 16;
    localparam int IDX_W            = 5;
    localparam int LEN_W            = 5;
    localparam int SUM_W            = IDX_W + 1;
    localparam int KEY_WORD_W       = LETTERS_PER_WORD * IDX_W;
    localparam int CFG_IDX_W        = 2;

    localparam logic [SUM_W-1:0] SUM_ONE_WRAP = SUM_W'(ALPHABET_SIZE);
    localparam logic [SUM_W-1:0] SUM_TWO_WRAP = SUM_W'(2 * ALPHABET_SIZE);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LENGTH = 2'd0,
        CFG_KEY_FIRST  = 2'd1,
        CFG_KEY_SECOND = 2'd2
    } t_cfg_reg;

    localparam logic [CODE_W-1:0] CH_UPPER_A   = 16'h0041;
    localparam logic [CODE_W-1:0] CH_UPPER_E   = 16'h0045;
    localparam logic [CODE_W-1:0] CH_UPPER_I   = 16'h0049;
    localparam logic [CODE_W-1:0] CH_UPPER_N   = 16'h004E;
    localparam logic [CODE_W-1:0] CH_UPPER_O   = 16'h004F;
    localparam logic [CODE_W-1:0] CH_UPPER_U   = 16'h0055;
    localparam logic [CODE_W-1:0] CH_UPPER_Z   = 16'h005A;
    localparam logic [CODE_W-1:0] CH_LOWER_A   = 16'h0061;
    localparam logic [CODE_W-1:0] CH_LOWER_Z   = 16'h007A;
    localparam logic [CODE_W-1:0] CASE_OFFSET  = 16'h0020;
    localparam logic [CODE_W-1:0] CH_N_TILDE   = 16'h00D1;
    localparam logic [CODE_W-1:0] CH_N_TILDE_L = 16'h00F1;
    localparam logic [CODE_W-1:0] CH_A_ACUTE   = 16'h00C1;
    localparam logic [CODE_W-1:0] CH_E_ACUTE   = 16'h00C9;
    localparam logic [CODE_W-1:0] CH_I_ACUTE   = 16'h00CD;
    localparam logic [CODE_W-1:0] CH_O_ACUTE   = 16'h00D3;
    localparam logic [CODE_W-1:0] CH_U_ACUTE   = 16'h00DA;
    localparam logic [CODE_W-1:0] CH_A_ACUTE_L = 16'h00E1;
    localparam logic [CODE_W-1:0] CH_E_ACUTE_L = 16'h00E9;
    localparam logic [CODE_W-1:0] CH_I_ACUTE_L = 16'h00ED;
    localparam logic [CODE_W-1:0] CH_O_ACUTE_L = 16'h00F3;
    localparam logic [CODE_W-1:0] CH_U_ACUTE_L = 16'h00FA;

    localparam logic [IDX_W-1:0] IDX_N_TILDE = 5'd14;
    localparam logic [IDX_W-1:0] IDX_UPPER_O = 5'd15;

    typedef struct packed {
        logic             keep;
        logic [IDX_W-1:0] index;
    } t_letter;

    function automatic logic [CODE_W-1:0] letter_code(input logic [IDX_W-1:0] idx);
        logic [CODE_W-1:0] code;
        if (idx < IDX_N_TILDE) begin
            code = CH_UPPER_A + CODE_W'(idx);
        end else if (idx == IDX_N_TILDE) begin
            code = CH_N_TILDE;
        end else begin
            code = CH_UPPER_O + CODE_W'(idx - IDX_UPPER_O);
        end
        return code;
    endfunction

endpackage

`default_nettype wire

### rtl/vigenere_cipher_spanish_alphabet.sv
// Top level of the Vigenere cipher over the 27-letter Spanish alphabet.
//
//  Channel   Handshake                  Payload
//  input     i_valid / o_ready          i_char_code, i_message_start
//  result    o_valid / i_ready          o_cipher_code, o_cipher_index
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One character per cycle unless the result stalls; a letter passes the input register
// and then the result register. The input register feeds the letter map, key lookup and
// modulo add into the result register; the key position register closes the loop.
// Dropped characters leave no result but still apply the message start flag.
// Reset: key length 1, key letters 0, key position 0, both stages empty.
// A stalled result holds the input stage; the config port is always ready.
`default_nettype none
`include "assert_macros.svh"

module vigenere_cipher_spanish_alphabet #(
    parameter int MAX_KEY_LETTERS = vgc_pkg::KEY_LETTERS_MAX
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [vgc_pkg::CODE_W-1:0]        i_char_code,
    input  wire logic                              i_message_start,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic      [vgc_pkg::CODE_W-1:0]        o_cipher_code,
    output logic      [vgc_pkg::IDX_W-1:0]         o_cipher_index,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [vgc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [vgc_pkg::KEY_WORD_W-1:0]    i_cfg_data
);
    import vgc_pkg::*;

    localparam int POS_W = (MAX_KEY_LETTERS > 1) ? $clog2(MAX_KEY_LETTERS) : 1;

    logic                 cfg_fire;
    t_cfg_reg             cfg_sel;
    logic [LEN_W-1:0]     r_key_length;
    logic [IDX_W-1:0]     r_key [MAX_KEY_LETTERS];
    logic [LEN_W-1:0]     eff_len;

    logic                 r_in_valid;
    logic [CODE_W-1:0]    r_char;
    logic                 r_start;
    logic                 advance;

    t_letter              letter;
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     n_pos;
    logic [POS_W-1:0]     pos_start;
    logic [POS_W-1:0]     pos_use;
    logic [LEN_W-1:0]     pos_inc;
    logic [IDX_W-1:0]     key_letter;
    logic [SUM_W-1:0]     sum;
    logic [IDX_W-1:0]     cipher;

    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [CODE_W-1:0]    r_out_code;
    logic [IDX_W-1:0]     r_out_index;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign cfg_sel     = t_cfg_reg'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= LEN_W'(1);
        end else if (cfg_fire && cfg_sel == CFG_KEY_LENGTH) begin
            r_key_length <= i_cfg_data[LEN_W-1:0];
        end
    end

    for (genvar g = 0; g < MAX_KEY_LETTERS; g++) begin : g_key
        localparam t_cfg_reg KEY_SEL = (g < LETTERS_PER_WORD) ? CFG_KEY_FIRST
                                                              : CFG_KEY_SECOND;
        localparam int KEY_LSB = (g % LETTERS_PER_WORD) * IDX_W;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_key[g] <= '0;
            end else if (cfg_fire && cfg_sel == KEY_SEL) begin
                r_key[g] <= i_cfg_data[KEY_LSB +: IDX_W];
            end
        end
    end

    always_comb begin
        if (r_key_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_key_length > LEN_W'(MAX_KEY_LETTERS)) begin
            eff_len = LEN_W'(MAX_KEY_LETTERS);
        end else begin
            eff_len = r_key_length;
        end
    end

    // input stage
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char  <= i_char_code;
            r_start <= i_message_start;
        end
    end

    vgc_letter_map u_letter_map (
        .i_char_code (r_char),
        .o_letter    (letter)
    );

    // key position and modulo add
    always_comb begin
        pos_start  = r_start ? '0 : r_pos;
        pos_use    = (LEN_W'(pos_start) >= eff_len) ? '0 : pos_start;
        key_letter = r_key[pos_use];
        pos_inc    = LEN_W'(pos_use) + LEN_W'(1);

        sum = SUM_W'(letter.index) + SUM_W'(key_letter);
        if (sum >= SUM_TWO_WRAP) begin
            cipher = IDX_W'(sum - SUM_TWO_WRAP);
        end else if (sum >= SUM_ONE_WRAP) begin
            cipher = IDX_W'(sum - SUM_ONE_WRAP);
        end else begin
            cipher = IDX_W'(sum);
        end

        n_pos = r_pos;
        if (advance) begin
            if (letter.keep) begin
                n_pos = (pos_inc >= eff_len) ? '0 : pos_inc[POS_W-1:0];
            end else begin
                n_pos = pos_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // result stage
    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (advance && letter.keep) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && letter.keep) begin
            r_out_code  <= letter_code(cipher);
            r_out_index <= cipher;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_cipher_code  = r_out_code;
    assign o_cipher_index = r_out_index;

    `ASSERT_PROP(a_letter_gives_result, i_clk, i_rst_n, (advance && letter.keep) |=> (o_valid && o_cipher_code == letter_code(o_cipher_index)), "kept letter did not reach the result register")

    `ASSERT_NEVER(a_index_range, i_clk, i_rst_n, (o_valid && o_cipher_index >= IDX_W'(ALPHABET_SIZE)), "cipher index outside the alphabet")

    `ASSERT_PROP(a_start_restarts_key, i_clk, i_rst_n, (advance && r_start && letter.keep && eff_len > LEN_W'(1)) |=> (r_pos == POS_W'(1)), "message start did not restart the key position")

endmodule

`default_nettype wire

### rtl/vgc_letter_map.sv
// Character code to 27-letter alphabet index, with accent and case folding.
`default_nettype none

module vgc_letter_map (
    input  wire logic [vgc_pkg::CODE_W-1:0] i_char_code,
    output vgc_pkg::t_letter                o_letter
);
    import vgc_pkg::*;

    logic [CODE_W-1:0] folded;

    always_comb begin
        case (i_char_code)
            CH_A_ACUTE, CH_A_ACUTE_L: folded = CH_UPPER_A;
            CH_E_ACUTE, CH_E_ACUTE_L: folded = CH_UPPER_E;
            CH_I_ACUTE, CH_I_ACUTE_L: folded = CH_UPPER_I;
            CH_O_ACUTE, CH_O_ACUTE_L: folded = CH_UPPER_O;
            CH_U_ACUTE, CH_U_ACUTE_L: folded = CH_UPPER_U;
            CH_N_TILDE_L:             folded = CH_N_TILDE;
            default:                  folded = i_char_code;
        endcase

        if (folded inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            folded = folded - CASE_OFFSET;
        end

        o_letter = '0;
        if (folded inside {[CH_UPPER_A:CH_UPPER_N]}) begin
            o_letter.keep  = 1'b1;
            o_letter.index = IDX_W'(folded - CH_UPPER_A);
        end else if (folded == CH_N_TILDE) begin
            o_letter.keep  = 1'b1;
            o_letter.index = IDX_N_TILDE;
        end else if (folded inside {[CH_UPPER_O:CH_UPPER_Z]}) begin
            o_letter.keep  = 1'b1;
            o_letter.index = IDX_W'(folded - CH_UPPER_O) + IDX_UPPER_O;
        end
    end

endmodule

`default_nettype wire

### test/tb.sv
// Testbench for the 27-letter Vigenere cipher: directed and random traffic checked against a predictor.
`timescale 1ns / 100ps

import vgc_pkg::*;

class cipher_scoreboard;
    typedef struct {
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  index;
    } t_cipher;

    t_cipher           cipher_q[$];
    logic [CODE_W-1:0] alphabet [ALPHABET_SIZE];
    logic [LEN_W-1:0]  key_len;
    logic [KEY_WORD_W-1:0] key_lo;
    logic [KEY_WORD_W-1:0] key_hi;
    int key_pos;
    int errors;
    int checked;
    int letters;
    int dropped;

    function new();
        int c;
        key_len = 1;
        key_lo  = '0;
        key_hi  = '0;
        key_pos = 0;
        errors  = 0;
        checked = 0;
        letters = 0;
        dropped = 0;
        for (c = CH_UPPER_A; c <= CH_UPPER_Z; c++) begin
            alphabet[letter_of(CODE_W'(c))] = CODE_W'(c);
        end
        alphabet[letter_of(CH_N_TILDE)] = CH_N_TILDE;
    endfunction

    function int letter_of(logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] c;
        c = code;
        case (c)
            CH_A_ACUTE, CH_A_ACUTE_L: c = CH_UPPER_A;
            CH_E_ACUTE, CH_E_ACUTE_L: c = CH_UPPER_E;
            CH_I_ACUTE, CH_I_ACUTE_L: c = CH_UPPER_I;
            CH_O_ACUTE, CH_O_ACUTE_L: c = CH_UPPER_O;
            CH_U_ACUTE, CH_U_ACUTE_L: c = CH_UPPER_U;
            CH_N_TILDE_L:             c = CH_N_TILDE;
            default: ;
        endcase
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_OFFSET;
        if (c >= CH_UPPER_A && c <= CH_UPPER_N) return int'(c - CH_UPPER_A);
        if (c == CH_N_TILDE) return int'(IDX_N_TILDE);
        if (c >= CH_UPPER_O && c <= CH_UPPER_Z) return int'(c - CH_UPPER_O) + int'(IDX_UPPER_O);
        return -1;
    endfunction

    function void write_reg(t_cfg_reg sel, logic [KEY_WORD_W-1:0] data);
        case (sel)
            CFG_KEY_LENGTH: key_len = data[LEN_W-1:0];
            CFG_KEY_FIRST:  key_lo  = data;
            CFG_KEY_SECOND: key_hi  = data;
            default: ;
        endcase
    endfunction

    function void note_char(logic [CODE_W-1:0] code, logic start);
        int idx;
        int len;
        int sum;
        t_cipher c;
        if (start) key_pos = 0;
        idx = letter_of(code);
        if (idx < 0) begin
            dropped++;
            return;
        end
        letters++;
        len = int'(key_len);
        if (len == 0) len = 1;
        if (len > KEY_LETTERS_MAX) len = KEY_LETTERS_MAX;
        if (key_pos >= len) key_pos = 0;
        if (key_pos < LETTERS_PER_WORD) begin
            sum = idx + int'(key_lo[IDX_W*key_pos +: IDX_W]);
        end else begin
            sum = idx + int'(key_hi[IDX_W*(key_pos-LETTERS_PER_WORD) +: IDX_W]);
        end
        while (sum >= ALPHABET_SIZE) sum -= ALPHABET_SIZE;
        key_pos = (key_pos + 1 >= len) ? 0 : key_pos + 1;
        c.code  = alphabet[sum];
        c.index = IDX_W'(sum);
        cipher_q.push_back(c);
    endfunction

    function void note_error(string msg);
        errors++;
        if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(logic [CODE_W-1:0] code, logic [IDX_W-1:0] index);
        t_cipher want;
        if (cipher_q.size() == 0) begin
            note_error($sformatf("unexpected result code %h index %0d", code, index));
            return;
        end
        want = cipher_q.pop_front();
        checked++;
        if (code !== want.code) begin
            note_error($sformatf("result %0d code: expected %h, got %h",
                                 checked, want.code, code));
        end
        if (index !== want.index) begin
            note_error($sformatf("result %0d index: expected %0d, got %0d",
                                 checked, want.index, index));
        end
    endfunction

    function int pending();
        return cipher_q.size();
    endfunction
endclass

module tb;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int N_PHASES         = 12;
    localparam int ITEMS_PER_PHASE  = 155;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_valid         = 1'b0;
    logic                  o_ready;
    logic [CODE_W-1:0]     i_char_code     = '0;
    logic                  i_message_start = 1'b0;
    logic                  o_valid;
    logic                  i_ready         = 1'b0;
    logic [CODE_W-1:0]     o_cipher_code;
    logic [IDX_W-1:0]      o_cipher_index;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = CFG_KEY_LENGTH;
    logic [KEY_WORD_W-1:0] i_cfg_data      = '0;

    cipher_scoreboard sb;
    bit tx_gaps   = 1'b0;
    bit rx_stalls = 1'b0;
    int ready_hold  = 0;
    int idle_cycles = 0;
    int chars_sent  = 0;
    int key_writes  = 0;

    vigenere_cipher_spanish_alphabet u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_code    (i_char_code),
        .i_message_start(i_message_start),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cipher_code  (o_cipher_code),
        .o_cipher_index (o_cipher_index),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_WORD_W-1:0] key_word(int mode);
        logic [KEY_WORD_W-1:0] w;
        int i;
        for (i = 0; i < LETTERS_PER_WORD; i++) begin
            case (mode)
                0:       w[IDX_W*i +: IDX_W] = '0;
                1:       w[IDX_W*i +: IDX_W] = '1;
                2:       w[IDX_W*i +: IDX_W] = IDX_W'(ALPHABET_SIZE - 1);
                3:       w[IDX_W*i +: IDX_W] = IDX_W'($urandom_range(0, ALPHABET_SIZE - 1));
                default: w[IDX_W*i +: IDX_W] = IDX_W'($urandom_range(0, 31));
            endcase
        end
        return w;
    endfunction

    function automatic logic [CODE_W-1:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return CH_UPPER_A + CODE_W'($urandom_range(0, 25));
        if (r < 55) return CH_LOWER_A + CODE_W'($urandom_range(0, 25));
        if (r < 65) begin
            case ($urandom_range(0, 11))
                0:  return CH_N_TILDE;
                1:  return CH_N_TILDE_L;
                2:  return CH_A_ACUTE;
                3:  return CH_E_ACUTE;
                4:  return CH_I_ACUTE;
                5:  return CH_O_ACUTE;
                6:  return CH_U_ACUTE;
                7:  return CH_A_ACUTE_L;
                8:  return CH_E_ACUTE_L;
                9:  return CH_I_ACUTE_L;
                10: return CH_O_ACUTE_L;
                default: return CH_U_ACUTE_L;
            endcase
        end
        if (r < 82) return CODE_W'($urandom_range(0, 255));
        return CODE_W'($urandom_range(0, 65535));
    endfunction

    // Enter and leave at a rising edge; the next call drives in the same step.
    task automatic send_char(input logic [CODE_W-1:0] code, input logic start);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_char_code     <= code;
        i_message_start <= start;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        sb.note_char(code, start);
        chars_sent++;
        @(posedge i_clk);
    endtask

    task automatic set_key(input logic [LEN_W-1:0] len, input logic [KEY_WORD_W-1:0] lo,
                           input logic [KEY_WORD_W-1:0] hi);
        t_cfg_reg sel [3];
        logic [KEY_WORD_W-1:0] data [3];
        int i;
        sel[0]  = CFG_KEY_LENGTH;
        sel[1]  = CFG_KEY_FIRST;
        sel[2]  = CFG_KEY_SECOND;
        data[0] = KEY_WORD_W'(len);
        data[1] = lo;
        data[2] = hi;
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        for (i = 0; i < 3; i++) begin
            i_cfg_index <= sel[i];
            i_cfg_data  <= data[i];
            @(negedge i_clk);
            while (!o_cfg_ready) @(negedge i_clk);
            sb.write_reg(sel[i], data[i]);
            key_writes++;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : rx_side
        int g;
        if (!rx_stalls) begin
            i_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            i_ready <= 1'b0;
        end else begin
            g = pick_gap();
            if (g > 0) begin
                ready_hold = g - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_cipher_code, o_cipher_index);
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, sb.pending());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int len_plan [8];
        logic [KEY_WORD_W-1:0] lo;
        int p;
        int n;
        int pos;
        int msg_len;
        logic start;
        len_plan = '{0, 1, 24, 31, 2, 25, 12, 13};
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (p = 0; p < LETTERS_PER_WORD; p++) lo[IDX_W*p +: IDX_W] = IDX_W'(p * 3);
        set_key(LEN_W'(5), lo, key_word(4));
        send_char(CH_UPPER_A, 1'b1);
        send_char(CH_UPPER_Z, 1'b0);
        send_char(CH_LOWER_A, 1'b0);
        send_char(CH_LOWER_Z, 1'b0);
        send_char(CH_UPPER_N, 1'b0);
        send_char(CH_UPPER_O, 1'b0);
        send_char(CH_N_TILDE, 1'b0);
        send_char(CH_N_TILDE_L, 1'b0);
        send_char(CH_A_ACUTE, 1'b0);
        send_char(CH_E_ACUTE, 1'b0);
        send_char(CH_I_ACUTE, 1'b0);
        send_char(CH_O_ACUTE, 1'b0);
        send_char(CH_U_ACUTE, 1'b0);
        send_char(CH_A_ACUTE_L, 1'b0);
        send_char(CH_E_ACUTE_L, 1'b0);
        send_char(CH_I_ACUTE_L, 1'b0);
        send_char(CH_O_ACUTE_L, 1'b0);
        send_char(CH_U_ACUTE_L, 1'b0);
        send_char(16'h0000, 1'b1);
        send_char(16'hFFFF, 1'b0);
        send_char(16'h0020, 1'b0);
        send_char(16'h0030, 1'b0);
        send_char(16'h00FC, 1'b0);
        send_char(16'h0141, 1'b0);
        send_char(16'h00C0, 1'b0);
        send_char(CH_UPPER_A, 1'b0);

        for (p = 0; p < N_PHASES; p++) begin
            set_key(p < 8 ? LEN_W'(len_plan[p]) : LEN_W'($urandom_range(0, 31)),
                    key_word(p % 5), key_word((p + 2) % 5));
            tx_gaps   = (p % 4 != 2);
            rx_stalls = (p % 4 != 3);
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                msg_len = $urandom_range(1, 30);
                for (pos = 0; pos < msg_len && n < ITEMS_PER_PHASE; pos++) begin
                    if (pos == 0) start = ($urandom_range(0, 9) != 0);
                    else          start = ($urandom_range(0, 39) == 0);
                    send_char(random_char(), start);
                    n++;
                end
            end
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);
        $display("Sent %0d characters (%0d letters, %0d dropped), %0d register writes",
                 chars_sent, sb.letters, sb.dropped, key_writes);
        $display("Checked %0d cipher letters over %0d key settings, %0d mismatches",
                 sb.checked, N_PHASES + 1, sb.errors);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
